// ===== rtl/core/rcf_pkg.sv =====
// ---------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the random colour crossfader
// Sequencer states, command and status bundles between the controller and
// the datapath, register indexes and reset values.
// ---------------------------------------------------------------------------
package rcf_pkg;

  // Channel and fade widths
  localparam int unsigned CH_W      = 8;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned PROD_W    = CH_W + FRAME_W;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned CH_IDX_W  = 2;
  localparam int unsigned QBIT_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_W     = 24;

  // Channel numbers
  localparam logic [CH_IDX_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_IDX_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_IDX_W-1:0] CH_BLUE  = 2'd2;

  // Top quotient bit of the fade division (quotient always below 256)
  localparam logic [QBIT_W-1:0] QBIT_TOP = 3'd7;
  localparam logic [QBIT_W-1:0] QBIT_LOW = 3'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GREEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLUE    = 2'd3;

  // Register reset values
  localparam logic [FRAME_W-1:0] FRAME_COUNT_RST = 16'd100;
  localparam logic [CH_W-1:0]    MAX_RST         = 8'd255;

  // Divide by three through a reciprocal: floor(s/3) == (s*683) >> 11 for s <= 765
  localparam int unsigned        AVG_RECIP_W = 11;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = 11'd683;
  localparam int unsigned        AVG_SHIFT   = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_EMIT_DARK
  } state_t;

  typedef struct packed {
    logic                load_in;
    logic                go_dark;
    logic                copy_start;
    logic                take_cand;
    logic                mul_load;
    logic                div_step;
    logic                emit;
    logic                advance;
    logic [CH_IDX_W-1:0] ch;
    logic [QBIT_W-1:0]   qbit;
  } dp_cmd_t;

  typedef struct packed {
    logic lamp_on;
    logic lit;
    logic need_new;
    logic cand_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/rcf_ctrl.sv =====
// ---------------------------------------------------------------------------
// rcf_ctrl: sequencer of the random colour crossfader
// Takes one request at a time, walks it through decision, candidate test,
// three multiply/divide passes and the hand-off to the output register.
// ---------------------------------------------------------------------------
module rcf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  rcf_pkg::dp_status_t status,
  output rcf_pkg::dp_cmd_t    cmd
);
  import rcf_pkg::*;

  state_t              state, state_next;
  logic [CH_IDX_W-1:0] ch_cnt, ch_cnt_next;
  logic [QBIT_W-1:0]   bit_cnt, bit_cnt_next;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ch_cnt  <= CH_RED;
      bit_cnt <= QBIT_TOP;
    end else begin
      state   <= state_next;
      ch_cnt  <= ch_cnt_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    ch_cnt_next   = ch_cnt;
    bit_cnt_next  = bit_cnt;
    cmd           = '0;
    cmd.ch        = ch_cnt;
    cmd.qbit      = bit_cnt;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!status.lamp_on) begin
          if (status.lit) begin
            cmd.go_dark = 1'b1;
            state_next  = ST_EMIT_DARK;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (status.need_new) begin
          cmd.copy_start = 1'b1;
          state_next     = ST_CHECK;
        end else begin
          ch_cnt_next = CH_RED;
          state_next  = ST_MUL;
        end
      end
      ST_CHECK: begin
        if (status.cand_ok) begin
          cmd.take_cand = 1'b1;
          ch_cnt_next   = CH_RED;
          state_next    = ST_MUL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        bit_cnt_next = QBIT_TOP;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_cnt == QBIT_LOW) begin
          if (ch_cnt == CH_BLUE) begin
            state_next = ST_EMIT;
          end else begin
            ch_cnt_next = ch_cnt + 2'd1;
            state_next  = ST_MUL;
          end
        end else begin
          bit_cnt_next = bit_cnt - 3'd1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_EMIT_DARK: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result handed over while output register busy");

  a_blue_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && bit_cnt == QBIT_LOW && ch_cnt == CH_BLUE) |=> state == ST_EMIT)
    else $error("last division step did not lead to emit");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == ST_IDLE)
    else $error("request taken outside idle");

endmodule

// ===== rtl/core/rcf_datapath.sv =====
// ---------------------------------------------------------------------------
// rcf_datapath: colour state, candidate test and fade arithmetic
// Holds configuration, start/target colours, fade index, the shared
// multiply and restoring divider, and the output register.
// ---------------------------------------------------------------------------
module rcf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcf_pkg::CFG_W-1:0]           cfg_data,
  input  logic [rcf_pkg::IN_W-1:0]            s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rcf_pkg::OUT_W-1:0]           m_axis_tdata,
  input  rcf_pkg::dp_cmd_t                    cmd,
  output rcf_pkg::dp_status_t                 status
);
  import rcf_pkg::*;

  // Configuration
  logic [FRAME_W-1:0] frame_count;
  logic [CH_W-1:0]    max_red, max_green, max_blue;

  // Latched request
  logic               lamp_on;
  logic [CH_W-1:0]    cand [NUM_CH];
  logic [SUM_W-1:0]   sum;

  // Colour state
  logic [CH_W-1:0]    start_color  [NUM_CH];
  logic [CH_W-1:0]    target_color [NUM_CH];
  logic [CH_W-1:0]    cur          [NUM_CH];
  logic [FRAME_W-1:0] fade_index;
  logic               lit;

  // Divider
  logic [PROD_W-1:0]  rem;
  logic [CH_W-1:0]    quot;

  logic [FRAME_W-1:0] frames;
  logic [CH_W-1:0]    s_sel, t_sel, diff;
  logic [PROD_W-1:0]  divisor_sh;
  logic               q_ge;
  logic [CH_W-1:0]    quot_next;
  logic [CH_W-1:0]    cur_new;

  logic [SUM_W+AVG_RECIP_W-1:0] avg_prod;
  logic [SUM_W-1:0]   avg;
  logic               below, in_window, far_r, far_g, far_b;

  function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RST;
      max_red     <= MAX_RST;
      max_green   <= MAX_RST;
      max_blue    <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT: frame_count <= cfg_data;
        REG_MAX_RED:     max_red     <= cfg_data[CH_W-1:0];
        REG_MAX_GREEN:   max_green   <= cfg_data[CH_W-1:0];
        REG_MAX_BLUE:    max_blue    <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero frame count behaves as one
  assign frames = (frame_count == '0) ? FRAME_W'(1) : frame_count;

  // Request latch and candidate sum
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lamp_on         <= s_axis_tdata[0];
      cand[CH_RED]    <= s_axis_tdata[8:1];
      cand[CH_GREEN]  <= s_axis_tdata[16:9];
      cand[CH_BLUE]   <= s_axis_tdata[24:17];
    end
    sum <= SUM_W'(cand[CH_RED]) + SUM_W'(cand[CH_GREEN]) + SUM_W'(cand[CH_BLUE]);
  end

  // Candidate test
  assign avg_prod  = (SUM_W+AVG_RECIP_W)'(sum) * (SUM_W+AVG_RECIP_W)'(AVG_RECIP);
  assign avg       = avg_prod[AVG_SHIFT +: SUM_W];
  assign below     = (cand[CH_RED] < max_red) && (cand[CH_GREEN] < max_green)
                     && (cand[CH_BLUE] < max_blue);
  assign in_window = (sum > SUM_W'(max_green)) && (sum <= {1'b0, max_green, 1'b0});
  assign far_r     = abs_diff(avg, SUM_W'(cand[CH_RED]))   > SUM_W'(max_red >> 1);
  assign far_g     = abs_diff(avg, SUM_W'(cand[CH_GREEN])) > SUM_W'(max_green >> 1);
  assign far_b     = abs_diff(avg, SUM_W'(cand[CH_BLUE]))  > SUM_W'(max_blue >> 1);

  // Channel selection and fade step
  assign s_sel      = start_color[cmd.ch];
  assign t_sel      = target_color[cmd.ch];
  assign diff       = (t_sel >= s_sel) ? (t_sel - s_sel) : (s_sel - t_sel);
  assign divisor_sh = PROD_W'(frames) << cmd.qbit;
  assign q_ge       = rem >= divisor_sh;
  always_comb begin
    quot_next = quot;
    quot_next[cmd.qbit] = q_ge;
  end
  assign cur_new = (t_sel >= s_sel) ? (s_sel + quot_next) : (s_sel - quot_next);

  // Multiply then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      rem  <= PROD_W'(diff) * PROD_W'(fade_index);
      quot <= '0;
    end else if (cmd.div_step) begin
      if (q_ge) begin
        rem <= rem - divisor_sh;
      end
      quot <= quot_next;
    end
  end

  // Colour state and fade index
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        start_color[i]  <= '0;
        target_color[i] <= '0;
      end
      fade_index <= '0;
      lit        <= 1'b0;
    end else begin
      if (cmd.go_dark) begin
        for (int i = 0; i < NUM_CH; i++) begin
          target_color[i] <= '0;
        end
        lit <= 1'b0;
      end
      if (cmd.copy_start) begin
        for (int i = 0; i < NUM_CH; i++) begin
          start_color[i] <= target_color[i];
        end
      end
      if (cmd.take_cand) begin
        for (int i = 0; i < NUM_CH; i++) begin
          target_color[i] <= cand[i];
        end
        fade_index <= '0;
        lit        <= 1'b1;
      end
      if (cmd.advance) begin
        fade_index <= fade_index + FRAME_W'(1);
      end
    end
  end

  // Current colour per channel
  always_ff @(posedge clk) begin
    if (cmd.go_dark) begin
      for (int i = 0; i < NUM_CH; i++) begin
        cur[i] <= '0;
      end
    end else if (cmd.div_step && cmd.qbit == QBIT_LOW) begin
      cur[cmd.ch] <= cur_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= {cur[CH_BLUE], cur[CH_GREEN], max_red - cur[CH_RED]};
    end
  end

  // Status to the sequencer
  always_comb begin
    status.lamp_on  = lamp_on;
    status.lit      = lit;
    status.need_new = (fade_index >= frames) || !lit;
    status.cand_ok  = below && in_window && (far_r || far_g || far_b);
    status.out_free = !m_axis_tvalid || m_axis_tready;
  end

  // Checks
  a_take_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.take_cand |=> lit && (fade_index == '0))
    else $error("new target did not restart the fade");

  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_load |=> rem < {frames, 8'b0})
    else $error("fade product exceeds eight-bit quotient range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

// ===== rtl/core/random_color_crossfader.sv =====
// ---------------------------------------------------------------------------
// random_color_crossfader: random colour crossfade for an RGB lamp
// Fades between randomly chosen colours one frame tick at a time.
// ---------------------------------------------------------------------------
// Usage:
//   One request on s_axis is one frame tick: the lamp-on flag and a candidate
//   colour from an external random source. A tick that yields a colour gives
//   one result on m_axis (red, green, blue PWM compare values); a tick whose
//   candidate fails the colour test, or a lamp-off tick while already dark,
//   gives none, and the next tick retries.
//   Configuration (frame count, channel maxima) is to be written on cfg_we
//   only while the block is idle; the block itself does not enforce this.
//   Sequence: a decision step, a candidate test step when a new target is
//   due, then per channel a multiply step and one divider step per bit of
//   the eight-bit quotient, then the hand-off to the output register. A
//   lamp-off tick while lit gives black through the dark hand-off step.
//   Requests are taken one at a time; the next is accepted once the previous
//   result has entered the output register, or once a tick without result
//   has been dropped.
//   Reset clears the start and target colours, fade index and lit flag and restores the
//   register defaults. If the receiver stalls, the result waits in the
//   output register while the next tick is worked on, which then holds
//   in its final step until the register frees.
// ---------------------------------------------------------------------------
module random_color_crossfader (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // lamp_on[0], cand_red[8:1], cand_green[16:9], cand_blue[24:17], zero fill
  input  logic [rcf_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // red_drive[7:0], green_drive[15:8], blue_drive[23:16]
  output logic [rcf_pkg::OUT_W-1:0]     m_axis_tdata
);
  import rcf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  rcf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // Arithmetic and state
  rcf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
